// ===== rtl/radar_track_association_unit_assert.svh =====
// Assertion macros for the radar track association unit.
// Needs no other file; the top level includes it by name.
`ifndef RADAR_TRACK_ASSOCIATION_UNIT_ASSERT_SVH
`define RADAR_TRACK_ASSOCIATION_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define RTAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);
// Check that a condition implies another in the same cycle.
`define RTAU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define RTAU_ASSERT(lbl, clk, rst, prop, msg)
`define RTAU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/rta_pkg.sv =====
// Types and constants for the radar track association unit.
// Standalone package; used by radar_track_association_unit.
package rta_pkg;

   localparam logic REQ_DETECTION = 1'b0;
   localparam logic REQ_END_FRAME = 1'b1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_GATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_LIMIT = 1'd1;

   localparam logic [15:0] RANGE_GATE_RESET = 16'd40;
   localparam logic [7:0]  MISS_LIMIT_RESET = 8'd5;
   localparam logic [7:0]  MISS_SATURATED   = 8'hFF;

   typedef struct packed {
      logic               req_type;
      logic        [15:0] det_range;
      logic signed [15:0] det_speed;
   } req_payload_type;

   typedef struct packed {
      logic        [7:0]  trk_id;
      logic        [15:0] trk_range;
      logic signed [15:0] trk_speed;
      logic        [7:0]  trk_missed;
      logic               table_overflow;
      logic               last_of_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic        [7:0]  ident;
      logic        [15:0] range;
      logic signed [15:0] speed;
      logic        [7:0]  miss;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DSCAN,
      ST_FAGE,
      ST_FEMIT
   } state_type;

endpackage

// ===== rtl/radar_track_association_unit.sv =====
// Radar track association unit: ordered track table with gated matching,
// miss aging and end-of-frame reporting. Depends on rta_pkg and on the
// assertion header radar_track_association_unit_assert.svh.
//
// Request channel: drive req_data and raise start; the request is taken at
// the rising edge where start is high and busy is low. busy stays high while
// the request is worked on, and drops before the next request is taken.
// Detection request: with n tracks the table is scanned one entry a cycle
// through the registered read port and stops at the first entry that matches.
// No result comes out.
// End-of-frame request: an aging pass over the n tracks compacts the table
// in place, then a report pass over the m kept tracks puts out one result
// per cycle on rsp_data, each marked by a one-cycle rsp_valid strobe;
// last_of_frame flags the final one. The receiver cannot stall.
// A new request is taken only after the previous one is done; the number
// of tracks in the table sets how long each request keeps busy high.
// Configuration: csr_ready is always high; write range_gate (index 0) or
// miss_limit (index 1) only while busy is low.
// Reset: synchronous, active high. The table comes up empty and needs no
// clearing pass; match flags and the overflow flag are cleared at once.
`include "radar_track_association_unit_assert.svh"

module radar_track_association_unit #(
   parameter int MAX_TRACKS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  rta_pkg::req_payload_type            req_data,
   // result channel
   output logic                                rsp_valid,
   output rta_pkg::rsp_payload_type            rsp_data,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rta_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rta_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IW = $clog2(MAX_TRACKS);      // table index width
   localparam int CW = $clog2(MAX_TRACKS + 1);  // track count width

   // state
   rta_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [15:0] gate_ff;
   logic [7:0]  limit_ff;

   // scan sequencer: issue stage reads, compare stage works on read data
   logic [CW-1:0] issue_ff, issue_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0] wr_ff, wr_in;

   // table bookkeeping
   logic [CW-1:0]         count_ff, count_in;
   logic [7:0]            last_id_ff, last_id_in;
   logic                  overflow_ff, overflow_in;
   logic [MAX_TRACKS-1:0] matched_ff, matched_in;

   // latched request
   rta_pkg::req_payload_type det_ff, det_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   rta_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // track memory: one write port, one registered read port
   rta_pkg::entry_type track_mem [MAX_TRACKS];
   rta_pkg::entry_type rdata_ff;
   logic               mem_we;
   logic [IW-1:0]      mem_wa;
   rta_pkg::entry_type mem_wd;
   logic [IW-1:0]      rd_addr;

   // shared compare unit
   logic        accept;
   logic        issue_go;
   logic        scan_end;
   logic [15:0] range_diff;
   logic        in_gate;
   logic        match_hit;
   logic [7:0]  aged_miss;
   logic        keep_track;
   logic        is_last;

   assign accept   = start && (state_ff == rta_pkg::ST_IDLE);
   assign issue_go = (issue_ff < count_ff);
   assign scan_end = !cmp_vld_ff && !issue_go;
   assign rd_addr  = issue_ff[IW-1:0];

   // absolute range difference against the latched detection
   assign range_diff = (rdata_ff.range >= det_ff.det_range) ?
                       (rdata_ff.range - det_ff.det_range) :
                       (det_ff.det_range - rdata_ff.range);
   assign in_gate    = (range_diff <= gate_ff);
   assign match_hit  = cmp_vld_ff && !matched_ff[cmp_idx_ff] && in_gate;

   // age an unmatched track, saturating at the top of the counter
   assign aged_miss  = matched_ff[cmp_idx_ff] ? rdata_ff.miss :
                       ((rdata_ff.miss == rta_pkg::MISS_SATURATED) ?
                        rdata_ff.miss : (rdata_ff.miss + 8'd1));
   assign keep_track = matched_ff[cmp_idx_ff] || (aged_miss < limit_ff);

   assign is_last = ((CW'(cmp_idx_ff) + CW'(1)) == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rta_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.req_type == rta_pkg::REQ_END_FRAME) ?
                          rta_pkg::ST_FAGE : rta_pkg::ST_DSCAN;
            end
         end
         rta_pkg::ST_DSCAN: begin
            if (match_hit || scan_end) begin
               state_in = rta_pkg::ST_IDLE;
            end
         end
         rta_pkg::ST_FAGE: begin
            if (scan_end) begin
               state_in = rta_pkg::ST_FEMIT;
            end
         end
         rta_pkg::ST_FEMIT: begin
            if (scan_end) begin
               state_in = rta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rta_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      wr_in        = wr_ff;
      count_in     = count_ff;
      last_id_in   = last_id_ff;
      overflow_in  = overflow_ff;
      matched_in   = matched_ff;
      det_in       = det_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = cmp_idx_ff;
      mem_wd       = rdata_ff;

      case (state_ff)
         rta_pkg::ST_IDLE: begin
            // rewind the scan and take a new request
            issue_in = '0;
            wr_in    = '0;
            if (accept) begin
               det_in = req_data;
            end
         end

         rta_pkg::ST_DSCAN: begin
            if (match_hit) begin
               // update the first free track inside the gate
               mem_we                 = 1'b1;
               mem_wa                 = cmp_idx_ff;
               mem_wd.ident           = rdata_ff.ident;
               mem_wd.range           = det_ff.det_range;
               mem_wd.speed           = det_ff.det_speed;
               mem_wd.miss            = 8'd0;
               matched_in[cmp_idx_ff] = 1'b1;
               issue_in               = '0;
            end else if (scan_end) begin
               issue_in = '0;
               if (count_ff == CW'(MAX_TRACKS)) begin
                  // table full: drop the detection
                  overflow_in = 1'b1;
               end else begin
                  // append a new track after the last one
                  mem_we       = 1'b1;
                  mem_wa       = count_ff[IW-1:0];
                  mem_wd.ident = (count_ff == '0) ? 8'd0 : (last_id_ff + 8'd1);
                  mem_wd.range = det_ff.det_range;
                  mem_wd.speed = det_ff.det_speed;
                  mem_wd.miss  = 8'd0;
                  last_id_in   = mem_wd.ident;
                  matched_in[count_ff[IW-1:0]] = 1'b1;
                  count_in     = count_ff + CW'(1);
               end
            end else if (issue_go) begin
               issue_in   = issue_ff + CW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IW-1:0];
            end
         end

         rta_pkg::ST_FAGE: begin
            if (cmp_vld_ff && keep_track) begin
               // compact in place: write slot never passes the read slot
               mem_we      = 1'b1;
               mem_wa      = wr_ff[IW-1:0];
               mem_wd      = rdata_ff;
               mem_wd.miss = aged_miss;
               wr_in       = wr_ff + CW'(1);
               last_id_in  = rdata_ff.ident;
            end
            if (scan_end) begin
               count_in   = wr_ff;
               matched_in = '0;
               issue_in   = '0;
            end else if (issue_go) begin
               issue_in   = issue_ff + CW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IW-1:0];
            end
         end

         rta_pkg::ST_FEMIT: begin
            if (cmp_vld_ff) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.trk_id         = rdata_ff.ident;
               rsp_data_in.trk_range      = rdata_ff.range;
               rsp_data_in.trk_speed      = rdata_ff.speed;
               rsp_data_in.trk_missed     = rdata_ff.miss;
               rsp_data_in.table_overflow = overflow_ff;
               rsp_data_in.last_of_frame  = is_last;
            end
            if (scan_end) begin
               issue_in = '0;
            end else if (issue_go) begin
               issue_in   = issue_ff + CW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IW-1:0];
            end
         end

         default: begin
            issue_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rta_pkg::ST_IDLE;
         issue_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         wr_ff        <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         matched_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         wr_ff        <= wr_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         matched_ff   <= matched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      last_id_ff  <= last_id_in;
      det_ff      <= det_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff  <= rta_pkg::RANGE_GATE_RESET;
         limit_ff <= rta_pkg::MISS_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rta_pkg::CSR_RANGE_GATE: gate_ff  <= csr_wdata;
            rta_pkg::CSR_MISS_LIMIT: limit_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // track memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         track_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= track_mem[rd_addr];
   end

   assign busy      = (state_ff != rta_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the table never holds more tracks than it has slots
   `RTAU_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_TRACKS),
      "track count above table size")
   // a result strobe follows only a report cycle
   `RTAU_ASSERT_IMPL(a_rsp_from_emit, clock, reset, rsp_valid_ff,
      $past(state_ff) == rta_pkg::ST_FEMIT, "result outside report pass")
   // match flags are all clear while reporting
   `RTAU_ASSERT_IMPL(a_flags_clear, clock, reset, state_ff == rta_pkg::ST_FEMIT,
      matched_ff == '0, "match flag left set after aging")

endmodule
